@@ rtl/core/npps_pkg.sv @@
// ----------------------------------------------------------------------------
// npps_pkg: shared types and constants for the priority scheduler
// Field widths, register indexes, controller states and the structs that
// travel along the row of process cells.
// ----------------------------------------------------------------------------
package npps_pkg;

	localparam int MAX_PROCS_DEF = 64;

	// widest index and count that the allowed MAX_PROCS range needs
	localparam int IDX_MAX_W = 8;
	localparam int CNT_MAX_W = 9;

	localparam int SLOT_W    = 6;
	localparam int ARR_W     = 8;
	localparam int RUN_W     = 8;
	localparam int PRIO_W    = 4;
	localparam int REM_W     = 10;
	localparam int WAIT_W    = 12;
	localparam int TICK_W    = 16;
	localparam int TURN_W    = 16;
	localparam int PC_W      = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [REM_W-1:0]  TICK_UNITS     = REM_W'(16);
	localparam logic [WAIT_W-1:0] WAIT_MAX       = '1;
	localparam logic [TICK_W-1:0] TICK_MAX       = '1;
	localparam logic [PC_W-1:0]   PC_RESET       = PC_W'(50);
	localparam logic [TICK_W-1:0] END_TICK_RESET = TICK_W'(100);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_COUNT = 1'b0,
		REG_END_TICK      = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN1,
		ST_RUN,
		ST_SCAN2,
		ST_RESULT
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                 load_en;
		logic [SLOT_W-1:0]    load_slot;
		logic [ARR_W-1:0]     load_arrival;
		logic [RUN_W-1:0]     load_run;
		logic [PRIO_W-1:0]    load_prio;
		logic                 run_en;
		logic [IDX_MAX_W-1:0] cur;
		logic [TICK_W-1:0]    now;
		logic [CNT_MAX_W-1:0] n;
	} cell_cmd_t;

	// selection record handed from cell to cell during a scan
	typedef struct packed {
		logic                 valid;
		logic                 any_ok;
		logic [IDX_MAX_W-1:0] first_idx;
		logic                 arr_ok;
		logic [IDX_MAX_W-1:0] best_idx;
		logic [PRIO_W-1:0]    best_prio;
		logic [REM_W-1:0]     best_rem;
		logic [WAIT_W-1:0]    best_wait;
		logic [RUN_W-1:0]     best_run;
		logic                 cur_ok;
		logic                 cur_arr;
		logic [REM_W-1:0]     cur_rem;
		logic [WAIT_W-1:0]    cur_wait;
		logic [RUN_W-1:0]     cur_run;
	} scan_tok_t;

endpackage

@@ rtl/core/npps_cell.sv @@
// ----------------------------------------------------------------------------
// npps_cell: one process table entry
// Holds arrival, run length, remaining time, priority, wait and finished
// mark of one slot, applies loads and tick updates, and folds itself into
// the selection record passing down the row.
// ----------------------------------------------------------------------------
module npps_cell #(
	parameter int INDEX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  npps_pkg::cell_cmd_t   cmd,
	input  npps_pkg::scan_tok_t   tok_in,
	output npps_pkg::scan_tok_t   tok_out,
	output logic                  pend
);
	import npps_pkg::*;

	logic [ARR_W-1:0]  arrival_q;
	logic [RUN_W-1:0]  runlen_q;
	logic [REM_W-1:0]  rem_q;
	logic [PRIO_W-1:0] prio_q;
	logic [WAIT_W-1:0] wait_q;
	logic              fin_q;

	scan_tok_t tok_pay_q;
	logic      tok_vld_q;
	scan_tok_t tok_nxt;

	logic in_range;
	logic arrived;
	logic is_cur;
	logic live;
	logic load_hit;

	assign in_range = 32'(cmd.n) > INDEX;
	assign arrived  = TICK_W'(arrival_q) < cmd.now;
	assign is_cur   = cmd.cur == IDX_MAX_W'(INDEX);
	assign live     = in_range && !fin_q;
	assign load_hit = cmd.load_en && (32'(cmd.load_slot) == INDEX);
	assign pend     = live;

	always_comb begin
		tok_nxt = tok_in;
		if (live) begin
			if (!tok_in.any_ok) begin
				tok_nxt.any_ok    = 1'b1;
				tok_nxt.first_idx = IDX_MAX_W'(INDEX);
			end
			// strict compare keeps the earlier slot on a tie
			if (arrived && (!tok_in.arr_ok || prio_q < tok_in.best_prio)) begin
				tok_nxt.arr_ok    = 1'b1;
				tok_nxt.best_idx  = IDX_MAX_W'(INDEX);
				tok_nxt.best_prio = prio_q;
				tok_nxt.best_rem  = rem_q;
				tok_nxt.best_wait = wait_q;
				tok_nxt.best_run  = runlen_q;
			end
			if (is_cur) begin
				tok_nxt.cur_ok   = 1'b1;
				tok_nxt.cur_arr  = arrived;
				tok_nxt.cur_rem  = rem_q;
				tok_nxt.cur_wait = wait_q;
				tok_nxt.cur_run  = runlen_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			tok_pay_q <= tok_nxt;
		end
	end

	always_comb begin
		tok_out       = tok_pay_q;
		tok_out.valid = tok_vld_q;
	end

	always_ff @(posedge clk) begin
		if (load_hit) begin
			arrival_q <= cmd.load_arrival;
			runlen_q  <= cmd.load_run;
			rem_q     <= REM_W'(cmd.load_run);
			prio_q    <= cmd.load_prio;
		end else if (cmd.run_en && live && is_cur) begin
			if (rem_q <= TICK_UNITS) begin
				rem_q <= '0;
			end else begin
				rem_q <= rem_q - TICK_UNITS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
			fin_q  <= 1'b0;
		end else if (load_hit) begin
			wait_q <= '0;
			fin_q  <= 1'b0;
		end else if (cmd.run_en && live) begin
			if (is_cur) begin
				if (rem_q <= TICK_UNITS) begin
					fin_q <= 1'b1;
				end
			end else if (arrived && wait_q != WAIT_MAX) begin
				wait_q <= wait_q + WAIT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/nonpreemptive_priority_scheduler.sv @@
// Load request: taken while idle, no result.
// Tick request: a first scan, the run step, a second scan when the running
// process finishes and the next one is chosen, then the result register;
// each scan walks the row of MAX_PROCS cells at one cell per cycle. One
// request at a time. After the run has ended a tick request skips the scans.
// Reset clears wait, finished marks, current slot, tick counter and run end.
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler: highest-priority-first process scheduler
// A controller steps a row of process cells through one tick: select when
// needed, run the current process, reselect after a completion, report.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler #(
	parameter int MAX_PROCS = npps_pkg::MAX_PROCS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [npps_pkg::SLOT_W-1:0]     slot,
	input  logic [npps_pkg::ARR_W-1:0]      arrival,
	input  logic [npps_pkg::RUN_W-1:0]      run_length,
	input  logic [npps_pkg::PRIO_W-1:0]     prio,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [npps_pkg::TICK_W-1:0]     tick,
	output logic                            busy_res,
	output logic [npps_pkg::SLOT_W-1:0]     running_slot,
	output logic                            finished,
	output logic [npps_pkg::WAIT_W-1:0]     wait_ticks,
	output logic [npps_pkg::TURN_W-1:0]     turnaround,
	output logic                            all_done,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [npps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [npps_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import npps_pkg::*;

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	state_t state_q, state_d;

	logic [PC_W-1:0]   pc_q;
	logic [TICK_W-1:0] end_tick_q;
	logic [IDX_W-1:0]  cur_q;
	logic [TICK_W-1:0] tick_q;
	logic              run_ended_q;
	logic              inj_q;
	logic              adv_q;
	logic              run_q;
	logic [REM_W-1:0]  rec_rem_q;
	logic [WAIT_W-1:0] rec_wait_q;
	logic [RUN_W-1:0]  rec_run_q;

	logic              res_busy_q;
	logic [IDX_W-1:0]  res_ran_q;
	logic              res_fin_q;
	logic [WAIT_W-1:0] res_wait_q;
	logic [TURN_W-1:0] res_turn_q;

	logic              out_valid_q;
	logic [TICK_W-1:0] tick_q_out;
	logic              busy_out_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic              fin_out_q;
	logic [WAIT_W-1:0] wait_out_q;
	logic [TURN_W-1:0] turn_out_q;
	logic              done_out_q;

	cell_cmd_t cmd;
	scan_tok_t tok_head;
	scan_tok_t chain [MAX_PROCS+1];
	scan_tok_t tok_last;
	logic [MAX_PROCS-1:0] pend_vec;

	logic [CNT_W-1:0]  n_act;
	logic              accept;
	logic              tick_req;
	logic              scan_done;
	logic              pend_any;
	logic [IDX_W-1:0]  sel_idx;
	logic              fin_now;
	logic              end_hit;
	logic [TURN_W:0]   turn_sum;
	logic [TURN_W-1:0] turn_sat;
	logic              out_go;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (pc_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(pc_q) > MAX_PROCS) begin
			n_act = CNT_W'(MAX_PROCS);
		end else begin
			n_act = CNT_W'(pc_q);
		end
	end

	assign accept    = in_valid && !in_stall;
	assign tick_req  = accept && (opcode == OP_TICK);
	assign tok_last  = chain[MAX_PROCS];
	assign scan_done = tok_last.valid;
	assign pend_any  = |pend_vec;
	assign fin_now   = run_q && (rec_rem_q <= TICK_UNITS);
	assign end_hit   = tick_q >= end_tick_q;
	assign turn_sum  = (TURN_W+1)'(rec_run_q) + (TURN_W+1)'({rec_wait_q, 4'b0000});
	assign turn_sat  = turn_sum[TURN_W] ? '1 : turn_sum[TURN_W-1:0];
	assign out_go    = !out_valid_q || !out_stall;

	// arrived best first, then lowest unfinished slot, else keep
	always_comb begin
		if (tok_last.arr_ok) begin
			sel_idx = IDX_W'(tok_last.best_idx);
		end else if (tok_last.any_ok) begin
			sel_idx = IDX_W'(tok_last.first_idx);
		end else begin
			sel_idx = cur_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_req) begin
					state_d = run_ended_q ? ST_RESULT : ST_SCAN1;
				end
			end
			ST_SCAN1: begin
				if (scan_done) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				state_d = (fin_now && !end_hit) ? ST_SCAN2 : ST_RESULT;
			end
			ST_SCAN2: begin
				if (scan_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_stall         = state_q != ST_IDLE;
		cmd.load_en      = (state_q == ST_IDLE) && in_valid && (opcode == OP_LOAD);
		cmd.load_slot    = slot;
		cmd.load_arrival = arrival;
		cmd.load_run     = run_length;
		cmd.load_prio    = prio;
		cmd.run_en       = (state_q == ST_RUN) && run_q;
		cmd.cur          = IDX_MAX_W'(cur_q);
		cmd.now          = tick_q;
		cmd.n            = CNT_MAX_W'(n_act);
		tok_head         = '0;
		tok_head.valid   = inj_q;
	end

	assign chain[0] = tok_head;

	for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
		npps_cell #(
			.INDEX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.tok_in (chain[g]),
			.tok_out(chain[g+1]),
			.pend   (pend_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= PC_RESET;
			end_tick_q <= END_TICK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PROCESS_COUNT: pc_q       <= cfg_data[PC_W-1:0];
				REG_END_TICK:      end_tick_q <= cfg_data[TICK_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inj_q       <= 1'b0;
			cur_q       <= '0;
			tick_q      <= '0;
			run_ended_q <= 1'b0;
			adv_q       <= 1'b0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			inj_q   <= (state_q == ST_IDLE && state_d == ST_SCAN1) ||
			           (state_q == ST_RUN && state_d == ST_SCAN2);
			if (state_q == ST_RESULT && out_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tick_req) begin
						adv_q <= !run_ended_q;
						run_q <= 1'b0;
					end
				end
				ST_SCAN1: begin
					if (scan_done) begin
						if (tok_last.cur_ok) begin
							run_q <= tok_last.cur_arr;
						end else begin
							cur_q <= sel_idx;
							run_q <= tok_last.arr_ok;
						end
					end
				end
				ST_RUN: begin
					if (fin_now && end_hit) begin
						run_ended_q <= 1'b1;
					end
				end
				ST_SCAN2: begin
					if (scan_done) begin
						cur_q <= sel_idx;
					end
				end
				ST_RESULT: begin
					if (out_go) begin
						if (adv_q && tick_q != TICK_MAX) begin
							tick_q <= tick_q + TICK_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// record of the process that may run, and the tick's result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tick_req) begin
			res_busy_q <= 1'b0;
			res_ran_q  <= '0;
			res_fin_q  <= 1'b0;
			res_wait_q <= '0;
			res_turn_q <= '0;
		end
		if (state_q == ST_SCAN1 && scan_done) begin
			if (tok_last.cur_ok) begin
				rec_rem_q  <= tok_last.cur_rem;
				rec_wait_q <= tok_last.cur_wait;
				rec_run_q  <= tok_last.cur_run;
			end else begin
				rec_rem_q  <= tok_last.best_rem;
				rec_wait_q <= tok_last.best_wait;
				rec_run_q  <= tok_last.best_run;
			end
		end
		if (state_q == ST_RUN) begin
			res_busy_q <= run_q;
			res_ran_q  <= run_q ? cur_q : '0;
			res_fin_q  <= fin_now;
			res_wait_q <= fin_now ? rec_wait_q : '0;
			res_turn_q <= fin_now ? turn_sat : '0;
		end
		if (state_q == ST_RESULT && out_go) begin
			tick_q_out <= tick_q;
			busy_out_q <= res_busy_q;
			slot_out_q <= SLOT_W'(res_ran_q);
			fin_out_q  <= res_fin_q;
			wait_out_q <= res_wait_q;
			turn_out_q <= res_turn_q;
			done_out_q <= run_ended_q || !pend_any;
		end
	end

	assign out_valid    = out_valid_q;
	assign tick         = tick_q_out;
	assign busy_res     = busy_out_q;
	assign running_slot = slot_out_q;
	assign finished     = fin_out_q;
	assign wait_ticks   = wait_out_q;
	assign turnaround   = turn_out_q;
	assign all_done     = done_out_q;

	a_fin_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!finished || busy_res))
		else $error("finished reported on an idle tick");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !busy_res) |->
			(running_slot == '0 && wait_ticks == '0 && turnaround == '0))
		else $error("idle tick carries nonzero slot or statistics");

	a_run_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		run_ended_q |=> run_ended_q)
		else $error("run end cleared without reset");

	a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == ST_SCAN1 || state_q == ST_SCAN2))
		else $error("selection record left the row outside a scan");

endmodule

@@ dv/sched_checker.sv @@
// ----------------------------------------------------------------------------
// sched_checker: tick report predictor and scoreboard for the scheduler
// Watches the request, result and register channels, keeps its own process
// table, predicts one report per accepted tick request and compares every
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sched_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           opcode,
	input  logic [npps_pkg::SLOT_W-1:0]    slot,
	input  logic [npps_pkg::ARR_W-1:0]     arrival,
	input  logic [npps_pkg::RUN_W-1:0]     run_length,
	input  logic [npps_pkg::PRIO_W-1:0]    prio,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [npps_pkg::TICK_W-1:0]    tick,
	input  logic                           busy_res,
	input  logic [npps_pkg::SLOT_W-1:0]    running_slot,
	input  logic                           finished,
	input  logic [npps_pkg::WAIT_W-1:0]    wait_ticks,
	input  logic [npps_pkg::TURN_W-1:0]    turnaround,
	input  logic                           all_done,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [npps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [npps_pkg::CFG_DAT_W-1:0] cfg_data,
	output int unsigned                    mismatches,
	output int unsigned                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import npps_pkg::*;

	localparam int PROCS = MAX_PROCS_DEF;

	typedef struct packed {
		logic [TICK_W-1:0] tick;
		logic              busy;
		logic [SLOT_W-1:0] slot;
		logic              fin;
		logic [WAIT_W-1:0] wt;
		logic [TURN_W-1:0] turn;
		logic              all_done;
	} tick_report_t;

	logic [ARR_W-1:0]  arr_tab  [PROCS];
	logic [RUN_W-1:0]  run_tab  [PROCS];
	logic [REM_W-1:0]  left_tab [PROCS];
	logic [PRIO_W-1:0] prio_tab [PROCS];
	logic [WAIT_W-1:0] wait_tab [PROCS];
	logic              done_tab [PROCS];
	int unsigned       cur_proc;
	logic [TICK_W-1:0] tick_cnt;
	logic              run_over;
	logic [PC_W-1:0]   proc_count;
	logic [TICK_W-1:0] stop_tick;

	tick_report_t tick_reports_q [$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic log_mismatch(input string msg);
		$display("ERROR %0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	function automatic int unsigned live_count();
		if (proc_count == 0)
			return 1;
		if (proc_count > PROCS)
			return PROCS;
		return proc_count;
	endfunction

	// lowest priority value among arrived entries, else lowest unfinished slot
	function automatic void pick_next(input int unsigned n, input int unsigned now);
		bit got_arrived;
		bit got_any;
		int unsigned best;
		int unsigned first;
		got_arrived = 0;
		got_any = 0;
		best = 0;
		first = 0;
		for (int unsigned k = 0; k < n; k++) begin
			if (!done_tab[k]) begin
				if (!got_any) begin
					got_any = 1;
					first = k;
				end
				if (arr_tab[k] < now && (!got_arrived || prio_tab[k] < prio_tab[best])) begin
					best = k;
					got_arrived = 1;
				end
			end
		end
		if (got_arrived)
			cur_proc = best;
		else if (got_any)
			cur_proc = first;
	endfunction

	function automatic bit none_open(input int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			if (!done_tab[k])
				return 0;
		return 1;
	endfunction

	function automatic tick_report_t predict_tick();
		tick_report_t r;
		int unsigned n;
		int unsigned now;
		int unsigned c;
		int unsigned turn;
		n = live_count();
		now = tick_cnt;
		r = '0;
		r.tick = tick_cnt;
		if (!run_over) begin
			if (cur_proc >= n || done_tab[cur_proc])
				pick_next(n, now);
			if (cur_proc < n && !done_tab[cur_proc] && arr_tab[cur_proc] < now) begin
				c = cur_proc;
				r.busy = 1'b1;
				r.slot = SLOT_W'(c);
				for (int unsigned k = 0; k < n; k++)
					if (k != c && !done_tab[k] && arr_tab[k] < now && wait_tab[k] != WAIT_MAX)
						wait_tab[k]++;
				if (left_tab[c] <= TICK_UNITS) begin
					left_tab[c] = '0;
					done_tab[c] = 1'b1;
					r.fin = 1'b1;
					r.wt = wait_tab[c];
					turn = run_tab[c] + wait_tab[c] * 16;
					if (turn > 65535)
						turn = 65535;
					r.turn = TURN_W'(turn);
					if (now >= stop_tick)
						run_over = 1'b1;
					else
						pick_next(n, now);
				end else begin
					left_tab[c] = left_tab[c] - TICK_UNITS;
				end
			end
			if (tick_cnt != TICK_MAX)
				tick_cnt++;
		end
		r.all_done = run_over || none_open(n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_report_t want;
		if (!arst_n) begin
			for (int k = 0; k < PROCS; k++) begin
				arr_tab[k] = '0;
				run_tab[k] = '0;
				left_tab[k] = '0;
				prio_tab[k] = '0;
				wait_tab[k] = '0;
				done_tab[k] = 1'b0;
			end
			cur_proc = 0;
			tick_cnt = '0;
			run_over = 1'b0;
			proc_count = PC_RESET;
			stop_tick = END_TICK_RESET;
			tick_reports_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tick_reports_q.size() == 0) begin
					log_mismatch("result with no request outstanding");
				end else begin
					want = tick_reports_q.pop_front();
					check_field("tick", tick, want.tick);
					check_field("busy_res", busy_res, want.busy);
					check_field("running_slot", running_slot, want.slot);
					check_field("finished", finished, want.fin);
					check_field("wait_ticks", wait_ticks, want.wt);
					check_field("turnaround", turnaround, want.turn);
					check_field("all_done", all_done, want.all_done);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_PROCESS_COUNT: proc_count = cfg_data[PC_W-1:0];
					REG_END_TICK:      stop_tick = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (opcode_t'(opcode) == OP_LOAD) begin
					arr_tab[slot] = arrival;
					run_tab[slot] = run_length;
					left_tab[slot] = REM_W'(run_length);
					prio_tab[slot] = prio;
					wait_tab[slot] = '0;
					done_tab[slot] = 1'b0;
				end else begin
					tick_reports_q.push_back(predict_tick());
				end
			end
			pending = tick_reports_q.size();
		end
	end

endmodule

@@ dv/nonpreemptive_priority_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_tb: stimulus and verdict for the scheduler
// Loads process tables and issues tick requests over several register
// settings, with random idling on both channels, a long result hold-off and
// a final run that ends on its first completion. The checker predicts and
// compares; this module only drives and reports the outcome.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import npps_pkg::*;

	localparam int          IDLE_PCT      = 15;
	localparam int          SETTLE_CYCLES = 150;
	localparam int          LONG_HOLD     = 400;
	localparam int unsigned ITEM_TARGET   = 650;
	localparam int          TICK_CAP      = 80;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	opcode_t              opcode       = OP_LOAD;
	logic [SLOT_W-1:0]    slot         = '0;
	logic [ARR_W-1:0]     arrival      = '0;
	logic [RUN_W-1:0]     run_length   = '0;
	logic [PRIO_W-1:0]    prio         = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [TICK_W-1:0]    tick;
	logic                 busy_res;
	logic [SLOT_W-1:0]    running_slot;
	logic                 finished;
	logic [WAIT_W-1:0]    wait_ticks;
	logic [TURN_W-1:0]    turnaround;
	logic                 all_done;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_DAT_W-1:0] cfg_data     = '0;
	int unsigned          mismatches;
	int unsigned          pending;

	bit          quiet      = 1'b0;
	bit          hold_now   = 1'b0;
	int unsigned items_sent = 0;
	int unsigned ticks_sent = 0;

	nonpreemptive_priority_scheduler dut (.*);

	sched_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, plus one long hold-off when asked
	initial begin
		int unsigned hold_left;
		bit calm;
		hold_left = 0;
		calm = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_now) begin
				hold_left = LONG_HOLD;
				hold_now = 1'b0;
			end
			calm = quiet;
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
			end
		end
	end

	// call right after a rising edge; returns at the edge that takes the request
	task automatic push_req(input opcode_t op, input logic [SLOT_W-1:0] s,
			input logic [ARR_W-1:0] a, input logic [RUN_W-1:0] r,
			input logic [PRIO_W-1:0] p);
		bit taken;
		while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		slot <= s;
		arrival <= a;
		run_length <= r;
		prio <= p;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		items_sent++;
		if (op == OP_TICK)
			ticks_sent++;
	endtask

	task automatic push_tick();
		push_req(OP_TICK, SLOT_W'($urandom), ARR_W'($urandom), RUN_W'($urandom),
			PRIO_W'($urandom));
	endtask

	// stop offering, wait out every report, then let a trailing load settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
	endtask

	task automatic program_regs(input logic [PC_W-1:0] pc, input logic [TICK_W-1:0] et);
		drain();
		cfg_write(REG_PROCESS_COUNT, CFG_DAT_W'(pc));
		cfg_write(REG_END_TICK, et);
		cfg_valid <= 1'b0;
	endtask

	// load every live slot in arrival order, then tick with stray loads mixed in
	task automatic run_phase(input logic [PC_W-1:0] pc, input logic [TICK_W-1:0] et,
			input bit hold);
		int unsigned live;
		int unsigned a_cur;
		int unsigned r;
		int unsigned budget;
		int unsigned s;
		int unsigned k;
		live = (pc == 0) ? 1 : (pc > MAX_PROCS_DEF) ? MAX_PROCS_DEF : pc;
		program_regs(pc, et);
		a_cur = (ticks_sent > 255) ? $urandom_range(255, 0) : ticks_sent + $urandom_range(3, 0);
		budget = 4;
		for (s = 0; s < live; s++) begin
			if (a_cur > 255)
				a_cur = 255;
			r = ($urandom_range(4, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(48, 0);
			budget += (r <= 16) ? 1 : (r + 15) / 16;
			push_req(OP_LOAD, SLOT_W'(s), ARR_W'(a_cur), RUN_W'(r),
				PRIO_W'($urandom_range(15, 0)));
			if ($urandom_range(3, 0) == 0)
				a_cur++;
		end
		if (budget > TICK_CAP)
			budget = TICK_CAP;
		if (hold)
			hold_now = 1'b1;
		for (k = 0; k < budget; k++) begin
			if ($urandom_range(99, 0) < 8)
				push_req(OP_LOAD, SLOT_W'($urandom), ARR_W'($urandom), RUN_W'($urandom),
					PRIO_W'($urandom));
			else
				push_tick();
		end
	endtask

	initial begin
		int unsigned phase;
		logic [PC_W-1:0] pc;
		logic [TICK_W-1:0] et;
		phase = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count zero acts as one: nothing arrived, run and finish, then all done
		program_regs('0, TICK_MAX);
		push_req(OP_LOAD, '0, '0, '0, '0);
		repeat (3) push_tick();

		// equal priority tie, priority extremes, run length boundaries,
		// an entry that never arrives and a load outside the count
		program_regs(PC_W'(4), TICK_MAX);
		push_req(OP_LOAD, SLOT_W'(63), 8'hFF, 8'hFF, 4'hF);
		push_req(OP_LOAD, SLOT_W'(0), 8'd2, 8'd33, 4'hF);
		push_req(OP_LOAD, SLOT_W'(1), 8'd2, 8'd16, 4'hF);
		push_req(OP_LOAD, SLOT_W'(2), 8'd3, 8'd17, 4'h0);
		push_req(OP_LOAD, SLOT_W'(3), 8'hFF, 8'd1, 4'h8);
		repeat (14) push_tick();

		// leave room for the overshoot of the last phase and the closing run
		while (items_sent < ITEM_TARGET - 60) begin
			case (phase % 7)
				0:       pc = PC_W'(64);
				1:       pc = PC_W'($urandom_range(12, 2));
				2:       pc = '1;
				3:       pc = PC_W'(1);
				4:       pc = PC_W'($urandom_range(24, 2));
				5:       pc = '0;
				default: pc = PC_W'($urandom_range(16, 2));
			endcase
			et = (phase % 3 == 0) ? TICK_MAX : TICK_W'($urandom_range(65535, 20000));
			quiet = (phase == 2);
			run_phase(pc, et, phase == 1);
			phase++;
		end
		quiet = 1'b0;

		// end the run on the first completion, then keep ticking past it
		run_phase(PC_W'(3), '0, 1'b0);
		repeat (6) push_tick();
		drain();

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
